### rtl/bdeq_pkg.sv
`default_nettype none

package bdeq_pkg;

    // fixed field widths of the channels
    localparam int VALUE_W  = 32;
    localparam int CFG_W    = 7;
    localparam int STATUS_W = 2;

    // capacity after reset
    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

endpackage

`default_nettype wire

### rtl/bdeq_if.sv
`default_nettype none

// command channel
interface bdeq_cmd_if;
    import bdeq_pkg::*;

    logic                 valid;
    logic                 ready;
    t_cmd                 cmd;
    logic signed [31:0]   value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// result channel
interface bdeq_res_if;
    import bdeq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [31:0]   value_out;
    t_status              status;
    logic                 is_full;
    logic                 is_empty;

    modport source (output valid, output value_out, output status, output is_full,
                    output is_empty, input ready);
    modport sink   (input valid, input value_out, input status, input is_full,
                    input is_empty, output ready);
endinterface

// capacity write channel
interface bdeq_cfg_if;
    import bdeq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [6:0]           capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

### rtl/bdeq_ram.sv
`default_nettype none

module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_addr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/bounded_array_deque.sv
`default_nettype none

// channel   | dir | transaction when      | payload
// ----------+-----+-----------------------+----------------------------------------
// i_cfg     | in  | valid && ready        | capacity (always ready)
// i_cmd     | in  | valid && ready        | cmd, value
// o_res     | out | valid && ready        | value_out, status, is_full, is_empty
//
// one command per cycle while results drain; every command gives one result, passing
// the read stage and then the output register (pointer update and slot access, then the slot read data)
// pointers live in flops, elements in a single-port ram with registered read data
// a held result stalls the read stage, which in turn holds ready low on i_cmd
// synchronous active-low reset empties the queue and sets capacity to its reset value;
// slot contents are not cleared, pops only reach slots written since reset

module bounded_array_deque #(
    parameter int DEPTH     = 64,
    parameter int DATA_BITS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bdeq_cfg_if.sink    i_cfg,
    bdeq_cmd_if.sink    i_cmd,
    bdeq_res_if.source  o_res
);
    import bdeq_pkg::*;

    // slot address and pointer widths; pointers are kept as position plus one
    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int EW      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    // stored element bits: the value field is 32 bits wide at most
    localparam int STORE_W = (DATA_BITS < VALUE_W) ? DATA_BITS : VALUE_W;

    // configuration
    logic [CFG_W-1:0]   r_cap;
    logic [EW-1:0]      cap_ext;
    logic [EW-1:0]      cap_eff;

    // pointers: front_ptr + 1 and rear_ptr + 1, both zero when empty after reset
    logic [CNT_W-1:0]   r_front;
    logic [CNT_W-1:0]   r_rear;
    logic [CNT_W-1:0]   n_front;
    logic [CNT_W-1:0]   n_rear;

    // ram access of the accepted command
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_addr;
    logic [STORE_W-1:0] ram_wdata;
    logic [STORE_W-1:0] ram_rdata;

    // command decode
    logic               cmd_fire;
    logic               full_now;
    logic               empty_now;
    logic               pop_ok;
    t_status            cmd_status;

    // read stage: waits for the registered ram data
    logic               r_s1_valid;
    logic               r_s1_pop;
    t_status            r_s1_status;
    logic               r_s1_full;
    logic               r_s1_empty;
    logic               s1_adv;

    // output register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    t_status            r_out_status;
    logic               r_out_full;
    logic               r_out_empty;
    logic [VALUE_W-1:0] s1_value;

    // ---------------------------------------------------------------------
    // capacity register, clamped to one .. DEPTH when used
    // ---------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg.valid) begin
            r_cap <= i_cfg.capacity;
        end
    end

    assign cap_ext = EW'(r_cap);

    always_comb begin
        if (r_cap == '0) begin
            cap_eff = EW'(1);
        end else if (cap_ext > EW'(DEPTH)) begin
            cap_eff = EW'(DEPTH);
        end else begin
            cap_eff = cap_ext;
        end
    end

    // ---------------------------------------------------------------------
    // command stage: decide, move at most one pointer, issue at most one slot access
    // ---------------------------------------------------------------------
    assign s1_adv       = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready  = !r_s1_valid || s1_adv;
    assign cmd_fire     = i_cmd.valid && i_cmd.ready;

    // full once rear_ptr reaches capacity - 1, also when capacity was lowered below fill
    assign full_now  = EW'(r_rear) >= cap_eff;
    assign empty_now = r_front == r_rear;
    assign ram_wdata = STORE_W'(i_cmd.value);

    always_comb begin
        n_front    = r_front;
        n_rear     = r_rear;
        cmd_status = ST_DONE;
        pop_ok     = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = r_rear[AW-1:0];
        unique case (i_cmd.cmd)
            CMD_PUSH_BACK: begin
                if (full_now) begin
                    cmd_status = ST_REFUSED;
                end else begin
                    // new rear slot is the old rear_ptr + 1
                    ram_we   = cmd_fire;
                    ram_addr = r_rear[AW-1:0];
                    n_rear   = r_rear + CNT_W'(1);
                end
            end
            CMD_PUSH_FRONT: begin
                // front room exists only after front pops
                if (r_front == '0) begin
                    cmd_status = ST_REFUSED;
                end else begin
                    ram_we   = cmd_fire;
                    ram_addr = AW'(r_front - CNT_W'(1));
                    n_front  = r_front - CNT_W'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (empty_now) begin
                    cmd_status = ST_EMPTY;
                end else begin
                    pop_ok   = 1'b1;
                    ram_re   = cmd_fire;
                    ram_addr = r_front[AW-1:0];
                    n_front  = r_front + CNT_W'(1);
                end
            end
            CMD_POP_BACK: begin
                if (empty_now) begin
                    cmd_status = ST_EMPTY;
                end else begin
                    // read the rear slot, then step back
                    pop_ok   = 1'b1;
                    ram_re   = cmd_fire;
                    ram_addr = AW'(r_rear - CNT_W'(1));
                    n_rear   = r_rear - CNT_W'(1);
                end
            end
            default: begin
                cmd_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
        end else if (cmd_fire) begin
            r_front <= n_front;
            r_rear  <= n_rear;
        end
    end

    // one access per cycle and the write lands before any later read is issued,
    // so a pop right after a push of the same slot sees the new element
    bdeq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------------
    // read stage: flags of the step travel beside the ram read
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (cmd_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_s1_pop    <= pop_ok;
            r_s1_status <= cmd_status;
            r_s1_full   <= EW'(n_rear) >= cap_eff;
            r_s1_empty  <= n_front == n_rear;
        end
    end

    // popped element, all ones for a pop on empty, zero for pushes
    always_comb begin
        if (r_s1_pop) begin
            s1_value = VALUE_W'(ram_rdata);
        end else if (r_s1_status == ST_EMPTY) begin
            s1_value = '1;
        end else begin
            s1_value = '0;
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_value  <= s1_value;
            r_out_status <= r_s1_status;
            r_out_full   <= r_s1_full;
            r_out_empty  <= r_s1_empty;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.value_out = r_out_value;
    assign o_res.status    = r_out_status;
    assign o_res.is_full   = r_out_full;
    assign o_res.is_empty  = r_out_empty;

`ifndef SYNTHESIS
    // stored span never inverts
    a_ptr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= r_rear)
        else $error("front pointer passed rear pointer");

    // rear never leaves the array
    a_rear_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rear <= CNT_W'(DEPTH))
        else $error("rear pointer beyond depth");

    // a successful pop reaches the read stage with a ram read behind it
    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_fire && pop_ok |=> r_s1_valid && r_s1_pop)
        else $error("pop lost its slot read");

    // a pop on empty leaves the queue empty and returns all ones
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_EMPTY |-> r_out_empty && r_out_value == '1)
        else $error("empty pop result inconsistent");

    // a refused push gives zero and never moves a pointer
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_fire && cmd_status == ST_REFUSED |=> $stable(r_front) && $stable(r_rear))
        else $error("refused push moved a pointer");
`endif

endmodule

`default_nettype wire
